// ----- sv/lbbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbbc_pkg: shared types and constants of the LRU block buffer cache
// Operation and status codes, slot geometry, controller/datapath bundles.
// ----------------------------------------------------------------------------
package lbbc_pkg;

	localparam int SLOT_COUNT     = 32;
	localparam int SLOT_BITS      = 5;
	localparam int TAG_BLOCK_BITS = 32;
	localparam int REF_BITS       = 8;
	localparam int DCNT_BITS      = 6;
	localparam logic [DCNT_BITS-1:0] FLUSH_THRESHOLD_RESET = 6'd29;
	localparam logic [REF_BITS-1:0]  REF_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_GET      = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_MARK     = 2'd2,
		OP_TRANSFER = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_NOREF   = 2'd2,
		ST_SATUR   = 2'd3
	} status_t;

	typedef struct packed {
		logic                 load;      // capture request
		logic                 scan_clr;  // reset scan index and best trackers
		logic                 scan_step; // compare one slot, advance index
		logic                 commit;    // apply the operation
		logic                 promote;   // make slot newest, one rank pass
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_last;   // index at last slot
		logic promote_req; // committed release dropped count to zero
	} ctl_sts_t;

endpackage

// ----- sv/lru_block_buffer_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: LRU disk-block buffer cache controller
// Tag lookup, victim selection, reference and dirty tracking for 32 slots.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: operation, device,
//                                              block_number, slot
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, granted_slot, hit,
//                                              needs_read, flush_needed, dirty_count
//  cfg       in   cfg_we                       cfg_wdata: flush_threshold
//
// get: the result beat follows a slot scan over all 32 slots, the commit and the
// rank update state; other operations skip the scan. One item at a time; the
// scan over the tag store bounds the rate. The block returns to idle after each taken result.
// Reset clears all slots at once; no clearing pass.
// A stalled result holds the block until taken.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit import lbbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // operation[1:0], device[9:2], block_number[41:10], slot[46:42]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // status[1:0], granted_slot[6:2], hit[7], needs_read[8], flush_needed[9], dirty_count[15:10]
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	ctl_cmd_t             cmd;
	ctl_sts_t             sts;
	logic [DCNT_BITS-1:0] thr_q;
	logic [1:0]           st;
	logic [SLOT_BITS-1:0] gs;
	logic                 h, nr, fl;
	logic [DCNT_BITS-1:0] dc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= FLUSH_THRESHOLD_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	lbbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_is_get (s_axis_tdata[1:0] == OP_GET),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	lbbc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_op          (s_axis_tdata[1:0]),
		.in_dev         (s_axis_tdata[9:2]),
		.in_blk         (s_axis_tdata[41:10]),
		.in_slot        (s_axis_tdata[46:42]),
		.threshold      (thr_q),
		.res_status     (st),
		.res_slot       (gs),
		.res_hit        (h),
		.res_needs_read (nr),
		.res_flush      (fl),
		.res_dcnt       (dc)
	);

	assign m_axis_tdata = {dc, fl, nr, h, gs, st};

endmodule

// ----- sv/lbbc_datapath.sv -----
// ----------------------------------------------------------------------------
// lbbc_datapath: slot state and scan logic
// Holds tags, marks, counts and ranks; scans slots one per cycle for the
// newest matching tag and the least recent free clean slot.
// ----------------------------------------------------------------------------
module lbbc_datapath import lbbc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_cmd_t                  cmd,
	output ctl_sts_t                  sts,
	input  logic [1:0]                in_op,
	input  logic [7:0]                in_dev,
	input  logic [31:0]               in_blk,
	input  logic [SLOT_BITS-1:0]      in_slot,
	input  logic [DCNT_BITS-1:0]      threshold,
	output logic [1:0]                res_status,
	output logic [SLOT_BITS-1:0]      res_slot,
	output logic                      res_hit,
	output logic                      res_needs_read,
	output logic                      res_flush,
	output logic [DCNT_BITS-1:0]      res_dcnt
);

	logic [7:0]                tag_dev_q [SLOT_COUNT];
	logic [TAG_BLOCK_BITS-1:0] tag_blk_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]     valid_q, dirty_q;
	logic [REF_BITS-1:0]       ref_q [SLOT_COUNT];
	logic [SLOT_BITS-1:0]      rank_q [SLOT_COUNT];

	logic [1:0]                op_q;
	logic [7:0]                dev_q;
	logic [TAG_BLOCK_BITS-1:0] blk_q;
	logic [SLOT_BITS-1:0]      slot_q;
	logic [SLOT_BITS-1:0]      idx_q;
	logic                      hit_f_q, vic_f_q, prom_q;
	logic [SLOT_BITS-1:0]      hit_s_q, hit_r_q, vic_s_q, vic_r_q;
	logic [DCNT_BITS-1:0]      dcnt_q;

	logic                      match, freec;
	logic [SLOT_BITS-1:0]      prom_r;

	assign match = (tag_dev_q[idx_q] == dev_q) && (tag_blk_q[idx_q] == blk_q);
	assign freec = (ref_q[idx_q] == '0) && !dirty_q[idx_q];
	assign prom_r = rank_q[slot_q];
	assign sts.scan_last = (idx_q == SLOT_BITS'(SLOT_COUNT-1));
	assign sts.promote_req = prom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			dcnt_q  <= '0;
			idx_q   <= '0;
			hit_f_q <= 1'b0;
			vic_f_q <= 1'b0;
			prom_q  <= 1'b0;
			res_status <= '0;
			res_slot <= '0;
			res_hit <= 1'b0;
			res_needs_read <= 1'b0;
			res_flush <= 1'b0;
			res_dcnt <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				tag_dev_q[i] <= '0;
				tag_blk_q[i] <= '0;
				ref_q[i]     <= '0;
				rank_q[i]    <= SLOT_BITS'(SLOT_COUNT-1-i);
			end
		end else begin
			if (cmd.load) begin
				op_q   <= in_op;
				dev_q  <= in_dev;
				blk_q  <= in_blk[TAG_BLOCK_BITS-1:0];
				slot_q <= in_slot;
				prom_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				idx_q   <= '0;
				hit_f_q <= 1'b0;
				vic_f_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (match && (!hit_f_q || rank_q[idx_q] < hit_r_q)) begin
					hit_f_q <= 1'b1;
					hit_s_q <= idx_q;
					hit_r_q <= rank_q[idx_q];
				end
				if (freec && (!vic_f_q || rank_q[idx_q] > vic_r_q)) begin
					vic_f_q <= 1'b1;
					vic_s_q <= idx_q;
					vic_r_q <= rank_q[idx_q];
				end
			end
			if (cmd.commit) begin
				res_status <= ST_OK;
				res_slot <= '0;
				res_hit <= 1'b0;
				res_needs_read <= 1'b0;
				res_flush <= 1'b0;
				res_dcnt <= dcnt_q;
				case (op_t'(op_q))
					OP_GET: begin
						res_flush <= (dcnt_q >= threshold);
						if (hit_f_q) begin
							res_slot <= hit_s_q;
							res_hit <= 1'b1;
							res_needs_read <= !valid_q[hit_s_q];
							if (ref_q[hit_s_q] == REF_MAX) res_status <= ST_SATUR;
							else ref_q[hit_s_q] <= ref_q[hit_s_q] + 1'b1;
						end else if (vic_f_q) begin
							res_slot <= vic_s_q;
							res_needs_read <= 1'b1;
							tag_dev_q[vic_s_q] <= dev_q;
							tag_blk_q[vic_s_q] <= blk_q;
							valid_q[vic_s_q] <= 1'b0;
							ref_q[vic_s_q] <= REF_BITS'(1);
						end else begin
							res_status <= ST_NOFREE;
						end
					end
					OP_RELEASE: begin
						if (ref_q[slot_q] == '0) res_status <= ST_NOREF;
						else begin
							ref_q[slot_q] <= ref_q[slot_q] - 1'b1;
							prom_q <= (ref_q[slot_q] == REF_BITS'(1));
						end
					end
					OP_MARK: begin
						if (ref_q[slot_q] == '0) res_status <= ST_NOREF;
						else if (!dirty_q[slot_q]) begin
							dirty_q[slot_q] <= 1'b1;
							dcnt_q <= dcnt_q + 1'b1;
							res_dcnt <= dcnt_q + 1'b1;
						end
					end
					default: begin
						valid_q[slot_q] <= 1'b1;
						if (dirty_q[slot_q]) begin
							dirty_q[slot_q] <= 1'b0;
							dcnt_q <= dcnt_q - 1'b1;
							res_dcnt <= dcnt_q - 1'b1;
						end
					end
				endcase
			end
			if (cmd.promote) begin
				prom_q <= 1'b0;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (rank_q[i] < prom_r) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[slot_q] <= '0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q == DCNT_BITS'($countones(dirty_q)))
		else $error("dirty count out of step with marks");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !cmd.commit)
		else $error("commit during scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.promote |-> $past(cmd.commit))
		else $error("promote without preceding commit");

endmodule

// ----- sv/lbbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbbc_ctrl: sequencer of the LRU block buffer cache
// Accepts a beat, runs the slot scan for get, commits, promotes a slot whose
// count a release dropped to zero, presents the result beat.
// ----------------------------------------------------------------------------
module lbbc_ctrl import lbbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     in_is_get,
	input  logic     out_ready,
	output logic     out_valid,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_PROMOTE, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load      = in_valid && in_ready;
		cmd.scan_clr  = in_valid && in_ready;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.commit    = (state_q == S_COMMIT);
		cmd.promote   = (state_q == S_PROMOTE) && sts.promote_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= in_is_get ? S_SCAN : S_COMMIT;
				S_SCAN: if (sts.scan_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_PROMOTE;
				S_PROMOTE: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					state_q   <= S_IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_OUT))
		else $error("result beat outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result beat dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !in_ready)
		else $error("ready during scan");

endmodule

// ----- test/lru_block_buffer_cache_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit_tb: self-checking bench of the block buffer cache
// Directed table then random get/release/mark/transfer traffic under several
// valid/ready idling phases; every result beat is checked against a cache model.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit_tb;
	import lbbc_pkg::*;

	typedef struct packed {
		logic [4:0]  slot;
		logic [31:0] blk;
		logic [7:0]  dev;
		op_t         op;
	} req_t;

	typedef struct packed {
		logic [5:0] dcnt;
		logic       flush;
		logic       nread;
		logic       hit;
		logic [4:0] gslot;
		status_t    status;
	} rsp_t;

	typedef struct {
		req_t req;
		logic fixed;
		rsp_t rsp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = '0;

	lru_block_buffer_cache_unit u_top (.*);

	always #1 clk = ~clk;

	logic [7:0]  c_dev [SLOT_COUNT];
	logic [31:0] c_blk [SLOT_COUNT];
	logic        c_val [SLOT_COUNT];
	logic        c_dirty [SLOT_COUNT];
	logic [7:0]  c_refs [SLOT_COUNT];
	logic [4:0]  c_rank [SLOT_COUNT];
	logic [5:0]  c_thresh;

	rsp_t pending_rsp [$];
	int   errors = 0;
	int   n_beats = 0;
	int   n_checked = 0;
	int   n_hits = 0;
	int   n_nofree = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	int   hold_recv = 0;
	longint cycles = 0;

	function automatic int dirty_total();
		int n;
		n = 0;
		for (int i = 0; i < SLOT_COUNT; i++) n += c_dirty[i];
		return n;
	endfunction

	function automatic rsp_t cache_apply(req_t q);
		rsp_t r;
		logic found;
		int g, d;
		r = '0;
		r.status = ST_OK;
		found = 1'b0;
		g = 0;
		if (q.op == OP_GET) begin
			r.flush = dirty_total() >= c_thresh;
			for (int k = 0; k < SLOT_COUNT && !found; k++)
				for (int i = 0; i < SLOT_COUNT; i++)
					if (!found && c_rank[i] == k && c_dev[i] == q.dev && c_blk[i] == q.blk) begin
						found = 1'b1;
						g = i;
					end
			if (found) begin
				r.hit = 1'b1;
				r.nread = !c_val[g];
				r.gslot = 5'(g);
				if (c_refs[g] == REF_MAX) r.status = ST_SATUR;
				else c_refs[g]++;
			end else begin
				for (int k = SLOT_COUNT - 1; k >= 0 && !found; k--)
					for (int i = 0; i < SLOT_COUNT; i++)
						if (!found && c_rank[i] == k && c_refs[i] == 0 && !c_dirty[i]) begin
							found = 1'b1;
							g = i;
						end
				if (found) begin
					c_dev[g] = q.dev;
					c_blk[g] = q.blk;
					c_val[g] = 1'b0;
					c_dirty[g] = 1'b0;
					c_refs[g] = 8'd1;
					r.nread = 1'b1;
					r.gslot = 5'(g);
				end else r.status = ST_NOFREE;
			end
		end else if (q.op == OP_RELEASE) begin
			if (c_refs[q.slot] == 0) r.status = ST_NOREF;
			else begin
				c_refs[q.slot]--;
				if (c_refs[q.slot] == 0) begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (c_rank[i] < c_rank[q.slot]) c_rank[i]++;
					c_rank[q.slot] = 0;
				end
			end
		end else if (q.op == OP_MARK) begin
			if (c_refs[q.slot] == 0) r.status = ST_NOREF;
			else c_dirty[q.slot] = 1'b1;
		end else begin
			c_val[q.slot] = 1'b1;
			c_dirty[q.slot] = 1'b0;
		end
		d = dirty_total();
		r.dcnt = 6'(d > 63 ? 63 : d);
		return r;
	endfunction

	task automatic send_req(req_t q, logic fixed, rsp_t want);
		rsp_t p;
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		p = cache_apply(q);
		if (fixed && p != want) begin
			$display("%0t table row disagrees with model: expected %h model %h", $time, want, p);
			errors++;
		end
		pending_rsp.push_back(fixed ? want : p);
		s_axis_tdata <= {1'b0, q};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_thresh(logic [5:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		c_thresh = v;
	endtask

	function automatic req_t rand_req(int nkeys);
		req_t q;
		int pick;
		q.blk = $urandom_range(nkeys - 1);
		if ($urandom_range(9) == 0) q.blk = $urandom;
		q.dev = 8'($urandom_range(9) == 0 ? $urandom : $urandom_range(1));
		q.slot = 5'($urandom);
		pick = $urandom_range(99);
		q.op = pick < 40 ? OP_GET : pick < 75 ? OP_RELEASE : pick < 88 ? OP_MARK : OP_TRANSFER;
		return q;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("lru_block_buffer_cache_unit_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_recv > 0) begin
			hold_recv <= hold_recv - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			n_beats++;
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected result beat: actual %h", $time, got);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				if (got.hit) n_hits++;
				if (got.status == ST_NOFREE) n_nofree++;
				if (got !== want) begin
					$display("%0t mismatch: expected st=%0d slot=%0d hit=%b rd=%b fl=%b dc=%0d",
						$time, want.status, want.gslot, want.hit, want.nread, want.flush,
						want.dcnt);
					$display("%0t            actual st=%0d slot=%0d hit=%b rd=%b fl=%b dc=%0d",
						$time, got.status, got.gslot, got.hit, got.nread, got.flush,
						got.dcnt);
					errors++;
				end
			end
		end
	end

	row_t table_rows [$];

	function automatic req_t mk(op_t o, logic [7:0] d, logic [31:0] b, logic [4:0] s);
		req_t q;
		q.op = o;
		q.dev = d;
		q.blk = b;
		q.slot = s;
		return q;
	endfunction

	function automatic rsp_t ok_get(logic [4:0] s, logic h, logic rd, logic [5:0] dc);
		rsp_t r;
		r = '0;
		r.status = ST_OK;
		r.gslot = s;
		r.hit = h;
		r.nread = rd;
		r.dcnt = dc;
		return r;
	endfunction

	function automatic rsp_t st_only(status_t st, logic [5:0] dc);
		rsp_t r;
		r = '0;
		r.status = st;
		r.dcnt = dc;
		return r;
	endfunction

	initial begin
		req_t q;
		int phase_items;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			c_dev[i] = '0;
			c_blk[i] = '0;
			c_val[i] = 1'b0;
			c_dirty[i] = 1'b0;
			c_refs[i] = '0;
			c_rank[i] = 5'(SLOT_COUNT - 1 - i);
		end
		c_thresh = FLUSH_THRESHOLD_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tags match device 0 block 0; newest such slot is 31
		table_rows.push_back('{mk(OP_GET, 0, 0, 0), 1, ok_get(31, 1, 1, 0)});
		table_rows.push_back('{mk(OP_RELEASE, 0, 0, 5), 1, st_only(ST_NOREF, 0)});
		table_rows.push_back('{mk(OP_MARK, 0, 0, 5), 1, st_only(ST_NOREF, 0)});
		table_rows.push_back('{mk(OP_GET, 8'hFF, 32'hFFFF_FFFF, 0), 1, ok_get(0, 0, 1, 0)});
		table_rows.push_back('{mk(OP_MARK, 0, 0, 0), 1, st_only(ST_OK, 1)});
		table_rows.push_back('{mk(OP_TRANSFER, 0, 0, 0), 1, st_only(ST_OK, 0)});
		table_rows.push_back('{mk(OP_GET, 8'hFF, 32'hFFFF_FFFF, 0), 1, ok_get(0, 1, 0, 0)});
		table_rows.push_back('{mk(OP_RELEASE, 0, 0, 0), 0, '0});
		table_rows.push_back('{mk(OP_RELEASE, 0, 0, 0), 0, '0});
		table_rows.push_back('{mk(OP_TRANSFER, 0, 0, 31), 0, '0});
		table_rows.push_back('{mk(OP_MARK, 0, 0, 31), 0, '0});
		table_rows.push_back('{mk(OP_GET, 8'h5A, 32'h1234_5678, 0), 0, '0});
		table_rows.push_back('{mk(OP_RELEASE, 0, 0, 31), 0, '0});
		table_rows.push_back('{mk(OP_GET, 8'hA5, 32'h8000_0000, 0), 0, '0});
		foreach (table_rows[i]) send_req(table_rows[i].req, table_rows[i].fixed, table_rows[i].rsp);

		// saturate one slot's count: 257 gets of the same tag
		for (int i = 0; i < 257; i++) send_req(mk(OP_GET, 8'h77, 32'h0000_0077, 0), 0, '0);
		for (int i = 0; i < 256; i++) send_req(mk(OP_RELEASE, 0, 0, 1), 0, '0);

		// fill every slot with references and dirt to exhaust free buffers
		write_thresh(6'd0);
		for (int i = 0; i < 34; i++) begin
			send_req(mk(OP_GET, 8'h10, 32'(i), 0), 0, '0);
		end
		for (int i = 0; i < 32; i++) send_req(mk(OP_MARK, 0, 0, 5'(i)), 0, '0);
		send_req(mk(OP_GET, 8'h11, 0, 0), 0, '0);
		for (int i = 0; i < 32; i++) send_req(mk(OP_TRANSFER, 0, 0, 5'(i)), 0, '0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; write_thresh(6'd32); end
				1: begin send_idle = 70; recv_stall = 0; write_thresh(6'd3); end
				2: begin send_idle = 0; recv_stall = 70; write_thresh(6'd63); end
				3: begin send_idle = 30; recv_stall = 30; write_thresh(6'd1); end
				default: begin send_idle = 0; recv_stall = 0; write_thresh(6'd16); end
			endcase
			if (ph == 4) hold_recv = 300;
			phase_items = ph == 0 ? 170 : 140;
			for (int i = 0; i < phase_items; i++) begin
				q = rand_req(ph == 2 ? 60 : 40);
				send_req(q, 0, '0);
				if (i == 120) begin
					s_axis_tvalid <= 1'b0;
					while (pending_rsp.size() != 0) @(posedge clk);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("covered %0d result beats (%0d checked), %0d hits, %0d no-free misses",
			n_beats, n_checked, n_hits, n_nofree);
		$display("thresholds 0..63 exercised, count saturation, all idling phases");
		if (errors == 0)
			$display("lru_block_buffer_cache_unit_tb: done, clean");
		else
			$display("lru_block_buffer_cache_unit_tb: done, errors");
		$finish;
	end

endmodule
